>>> rtl/core/chol_pkg.sv
`default_nettype none
package chol_pkg;
	localparam int MAX_DIM = 48;
	localparam int FRAC_BITS = 24;
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int MAX_PC = MAX_DIM / 6;
	localparam int CFG_W = 31;
	localparam logic CFG_IDX_PC = 1'b0;
	localparam logic CFG_IDX_NS = 1'b1;
	localparam logic MODE_ELEM = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic mode;
		logic [5:0] row;
		logic [5:0] col;
		logic signed [31:0] value;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [5:0] index;
		logic signed [31:0] displacement;
		logic not_pos_def;
		logic final_res;
	} out_item_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACC_CLR_DIAG,
		OP_ACC_CLR_OFF,
		OP_ACC_CLR_OUT,
		OP_ACC_SUB,
		OP_ACC_ADD,
		OP_SQRT_START,
		OP_DIV_START,
		OP_OUT_START
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIAG_INIT,
		ST_DIAG_RD,
		ST_DIAG_ACC,
		ST_SQRT,
		ST_PIV_WR,
		ST_OFF_INIT,
		ST_OFF_RD,
		ST_OFF_ACC,
		ST_DIV,
		ST_OFF_WR,
		ST_OUT_INIT,
		ST_OUT_RD,
		ST_OUT_ACC,
		ST_OUT_MUL,
		ST_OUT_EMIT
	} state_t;

	typedef struct packed {
		op_t op;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
		logic [IDX_W-1:0] samp_addr;
		logic wr_piv;
		logic wr_off;
		logic [ADDR_W-1:0] wr_addr;
		logic emit;
		logic [IDX_W-1:0] emit_idx;
		logic emit_final;
	} ctrl_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic mul_done;
		logic piv_zero;
	} stat_t;

	function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else sat_add64 = s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [63:0] x);
		if (x > 64'sh7fffffff) sat32 = 32'sh7fffffff;
		else if (x < -64'sh80000000) sat32 = 32'sh80000000;
		else sat32 = x[31:0];
	endfunction

	function automatic logic signed [63:0] rnd_shift(logic signed [63:0] x);
		logic signed [63:0] t;
		t = sat_add64(x, 64'sd1 <<< (FRAC_BITS - 1));
		rnd_shift = t >>> FRAC_BITS;
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/chol_ram.sv
`default_nettype none
module chol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/core/chol_datapath.sv
`default_nettype none
module chol_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load_we,
	input wire chol_pkg::in_item_t load_item,
	input wire chol_pkg::ctrl_t ctrl,
	input wire logic [30:0] noise_scale,
	input wire logic bad,
	output chol_pkg::stat_t stat,
	output logic res_strobe,
	output chol_pkg::out_item_t res
);
	localparam int AW = chol_pkg::ADDR_W;
	localparam int IW = chol_pkg::IDX_W;

	// two read ports realized as two copies of the matrix
	logic we_m;
	logic [AW-1:0] waddr_m;
	logic [31:0] wdata_m, rd_a, rd_b, rd_s;
	logic [31:0] piv_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod;

	// sqrt state
	logic [63:0] sq_v_q, sq_res_q, sq_bit_q;
	logic sq_busy_q;
	// divider state
	logic [63:0] dv_rem_q, dv_quo_q;
	logic [6:0] dv_cnt_q;
	logic dv_busy_q, dv_neg_q;
	logic [31:0] quo_out;
	// output multiply stage
	logic [1:0] mul_cnt_q;
	logic signed [31:0] v_s1;
	logic signed [63:0] m_s2;

	always_comb begin
		we_m = load_we || ctrl.wr_piv || ctrl.wr_off;
		if (load_we) begin
			waddr_m = AW'(load_item.row * chol_pkg::MAX_DIM + load_item.col);
			wdata_m = load_item.value;
		end else begin
			waddr_m = ctrl.wr_addr;
			// a zero pivot clears the column below it
			wdata_m = (ctrl.wr_piv || piv_q == '0) ? piv_q : quo_out;
		end
	end

	chol_ram #(.WIDTH(32), .DEPTH(chol_pkg::MAX_DIM * chol_pkg::MAX_DIM)) u_ma (
		.clk(clk), .we(we_m && !(load_we && load_item.mode == chol_pkg::MODE_SAMPLE)),
		.waddr(waddr_m), .wdata(wdata_m), .raddr(ctrl.addr_a), .rdata(rd_a));
	chol_ram #(.WIDTH(32), .DEPTH(chol_pkg::MAX_DIM * chol_pkg::MAX_DIM)) u_mb (
		.clk(clk), .we(we_m && !(load_we && load_item.mode == chol_pkg::MODE_SAMPLE)),
		.waddr(waddr_m), .wdata(wdata_m), .raddr(ctrl.addr_b), .rdata(rd_b));
	chol_ram #(.WIDTH(32), .DEPTH(chol_pkg::MAX_DIM)) u_s (
		.clk(clk), .we(load_we && load_item.mode == chol_pkg::MODE_SAMPLE),
		.waddr(load_item.row[IW-1:0]), .wdata(load_item.value),
		.raddr(ctrl.samp_addr), .rdata(rd_s));

	logic signed [31:0] opb;
	assign opb = (ctrl.op == chol_pkg::OP_ACC_ADD) ? $signed(rd_s) : $signed(rd_b);
	assign prod = $signed(rd_a) * opb;

	assign quo_out = chol_pkg::sat32(dv_neg_q ? -$signed(dv_quo_q) : $signed(dv_quo_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			dv_busy_q <= 1'b0;
			mul_cnt_q <= '0;
		end else begin
			unique case (ctrl.op)
				chol_pkg::OP_ACC_CLR_DIAG, chol_pkg::OP_ACC_CLR_OFF:
					acc_q <= $signed(rd_a) <<< chol_pkg::FRAC_BITS;
				chol_pkg::OP_ACC_CLR_OUT: acc_q <= '0;
				chol_pkg::OP_ACC_SUB: acc_q <= chol_pkg::sat_add64(acc_q, -prod);
				chol_pkg::OP_ACC_ADD: acc_q <= chol_pkg::sat_add64(acc_q, prod);
				default: ;
			endcase
			// restoring square root, one step per cycle
			if (ctrl.op == chol_pkg::OP_SQRT_START) begin
				sq_v_q <= acc_q > 0 ? acc_q : '0;
				sq_res_q <= '0;
				sq_bit_q <= 64'd1 << 62;
				sq_busy_q <= 1'b1;
			end else if (sq_busy_q) begin
				if (sq_bit_q == 0) begin
					sq_busy_q <= 1'b0;
					piv_q <= (sq_res_q > 64'h7fffffff) ? 32'h7fffffff : sq_res_q[31:0];
				end else begin
					if (sq_v_q >= sq_res_q + sq_bit_q) begin
						sq_v_q <= sq_v_q - (sq_res_q + sq_bit_q);
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else sq_res_q <= sq_res_q >> 1;
					sq_bit_q <= sq_bit_q >> 2;
				end
			end
			// restoring divider on magnitudes, one quotient bit per cycle
			if (ctrl.op == chol_pkg::OP_DIV_START) begin
				dv_neg_q <= acc_q[63];
				dv_quo_q <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
				dv_rem_q <= '0;
				dv_cnt_q <= 7'd64;
				dv_busy_q <= 1'b1;
			end else if (dv_busy_q) begin
				if (dv_cnt_q == 0) dv_busy_q <= 1'b0;
				else begin
					logic [64:0] r;
					r = {dv_rem_q, dv_quo_q[63]};
					if (r >= {33'd0, piv_q}) begin
						dv_rem_q <= 64'(r - {33'd0, piv_q});
						dv_quo_q <= {dv_quo_q[62:0], 1'b1};
					end else begin
						dv_rem_q <= r[63:0];
						dv_quo_q <= {dv_quo_q[62:0], 1'b0};
					end
					dv_cnt_q <= dv_cnt_q - 7'd1;
				end
			end
			// output scaling, two registered steps
			if (ctrl.op == chol_pkg::OP_OUT_START) begin
				v_s1 <= chol_pkg::sat32(chol_pkg::rnd_shift(acc_q));
				mul_cnt_q <= 2'd1;
			end else if (mul_cnt_q == 2'd1) begin
				m_s2 <= v_s1 * $signed({1'b0, noise_scale});
				mul_cnt_q <= 2'd2;
			end else if (mul_cnt_q == 2'd2) mul_cnt_q <= 2'd0;
		end
	end

	assign stat.sqrt_done = !sq_busy_q && ctrl.op != chol_pkg::OP_SQRT_START;
	assign stat.div_done = !dv_busy_q && ctrl.op != chol_pkg::OP_DIV_START;
	assign stat.mul_done = mul_cnt_q == 2'd2;
	assign stat.piv_zero = piv_q == 0;

	assign res_strobe = ctrl.emit;
	assign res.index = 6'(ctrl.emit_idx);
	assign res.displacement = chol_pkg::sat32(chol_pkg::rnd_shift(m_s2));
	assign res.not_pos_def = bad;
	assign res.final_res = ctrl.emit_final;
endmodule
`default_nettype wire

>>> rtl/core/chol_ctrl.sv
`default_nettype none
module chol_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic [3:0] particle_count,
	input wire chol_pkg::stat_t stat,
	output logic busy,
	output logic bad,
	output chol_pkg::ctrl_t ctrl
);
	localparam int AW = chol_pkg::ADDR_W;
	localparam int IW = chol_pkg::IDX_W;
	chol_pkg::state_t st_q, st_d;
	logic [IW-1:0] j_q, i_q, k_q, n_q;
	logic bad_q;

	logic [3:0] pc;
	always_comb begin
		pc = particle_count;
		if (pc == 0) pc = 4'd1;
		if (pc > 4'(chol_pkg::MAX_PC)) pc = 4'(chol_pkg::MAX_PC);
	end

	function automatic logic [AW-1:0] adr(logic [IW-1:0] r, logic [IW-1:0] c);
		adr = AW'(r * chol_pkg::MAX_DIM + c);
	endfunction

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			chol_pkg::ST_IDLE: if (go) st_d = chol_pkg::ST_DIAG_INIT;
			chol_pkg::ST_DIAG_INIT: st_d = chol_pkg::ST_DIAG_RD;
			chol_pkg::ST_DIAG_RD: st_d = chol_pkg::ST_DIAG_ACC;
			chol_pkg::ST_DIAG_ACC: st_d = (k_q == j_q) ? chol_pkg::ST_SQRT
				: chol_pkg::ST_DIAG_ACC;
			chol_pkg::ST_SQRT: if (stat.sqrt_done) st_d = chol_pkg::ST_PIV_WR;
			chol_pkg::ST_PIV_WR: st_d = (j_q + 1'b1 == n_q) ? chol_pkg::ST_OUT_INIT
				: chol_pkg::ST_OFF_INIT;
			chol_pkg::ST_OFF_INIT: st_d = chol_pkg::ST_OFF_RD;
			chol_pkg::ST_OFF_RD: st_d = chol_pkg::ST_OFF_ACC;
			chol_pkg::ST_OFF_ACC: if (k_q == j_q) st_d = stat.piv_zero ?
				chol_pkg::ST_OFF_WR : chol_pkg::ST_DIV;
			chol_pkg::ST_DIV: if (stat.div_done) st_d = chol_pkg::ST_OFF_WR;
			chol_pkg::ST_OFF_WR: st_d = (i_q + 1'b1 == n_q) ? chol_pkg::ST_DIAG_INIT
				: chol_pkg::ST_OFF_INIT;
			chol_pkg::ST_OUT_INIT: st_d = chol_pkg::ST_OUT_RD;
			chol_pkg::ST_OUT_RD: st_d = chol_pkg::ST_OUT_ACC;
			chol_pkg::ST_OUT_ACC: if (k_q == i_q + 1'b1) st_d = chol_pkg::ST_OUT_MUL;
			chol_pkg::ST_OUT_MUL: if (stat.mul_done) st_d = chol_pkg::ST_OUT_EMIT;
			chol_pkg::ST_OUT_EMIT: st_d = (i_q + 1'b1 == n_q) ? chol_pkg::ST_IDLE
				: chol_pkg::ST_OUT_INIT;
			default: st_d = chol_pkg::ST_IDLE;
		endcase
	end

	// k_q indexes the operands in use in the accumulate states; reads are issued in the cycle before their data is used
	always_comb begin
		ctrl = '0;
		ctrl.op = chol_pkg::OP_NONE;
		unique case (st_q)
			chol_pkg::ST_DIAG_INIT: ctrl.addr_a = adr(j_q, j_q);
			chol_pkg::ST_DIAG_RD: begin
				ctrl.op = chol_pkg::OP_ACC_CLR_DIAG;
				ctrl.addr_a = adr(j_q, k_q);
				ctrl.addr_b = adr(j_q, k_q);
			end
			chol_pkg::ST_DIAG_ACC: begin
				ctrl.op = (k_q == j_q) ? chol_pkg::OP_SQRT_START : chol_pkg::OP_ACC_SUB;
				ctrl.addr_a = adr(j_q, k_q + 1'b1);
				ctrl.addr_b = adr(j_q, k_q + 1'b1);
			end
			chol_pkg::ST_PIV_WR: begin
				ctrl.wr_piv = 1'b1;
				ctrl.wr_addr = adr(j_q, j_q);
			end
			chol_pkg::ST_OFF_INIT: ctrl.addr_a = adr(i_q, j_q);
			chol_pkg::ST_OFF_RD: begin
				ctrl.op = chol_pkg::OP_ACC_CLR_OFF;
				ctrl.addr_a = adr(i_q, k_q);
				ctrl.addr_b = adr(j_q, k_q);
			end
			chol_pkg::ST_OFF_ACC: begin
				ctrl.op = (k_q == j_q) ? (stat.piv_zero ? chol_pkg::OP_NONE
					: chol_pkg::OP_DIV_START) : chol_pkg::OP_ACC_SUB;
				ctrl.addr_a = adr(i_q, k_q + 1'b1);
				ctrl.addr_b = adr(j_q, k_q + 1'b1);
			end
			chol_pkg::ST_OFF_WR: begin
				ctrl.wr_off = 1'b1;
				ctrl.wr_addr = adr(i_q, j_q);
			end
			chol_pkg::ST_OUT_INIT: begin
				ctrl.op = chol_pkg::OP_ACC_CLR_OUT;
				ctrl.addr_a = adr(i_q, '0);
				ctrl.samp_addr = '0;
			end
			// column zero arrives here; the sum runs over columns 0..i
			chol_pkg::ST_OUT_RD: begin
				ctrl.op = chol_pkg::OP_ACC_ADD;
				ctrl.addr_a = adr(i_q, k_q + 1'b1);
				ctrl.samp_addr = k_q + 1'b1;
			end
			chol_pkg::ST_OUT_ACC: begin
				ctrl.op = (k_q == i_q + 1'b1) ? chol_pkg::OP_OUT_START
					: chol_pkg::OP_ACC_ADD;
				ctrl.addr_a = adr(i_q, k_q + 1'b1);
				ctrl.samp_addr = k_q + 1'b1;
			end
			chol_pkg::ST_OUT_EMIT: begin
				ctrl.emit = 1'b1;
				ctrl.emit_idx = i_q;
				ctrl.emit_final = (i_q + 1'b1 == n_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= chol_pkg::ST_IDLE;
			j_q <= '0; i_q <= '0; k_q <= '0; n_q <= '0; bad_q <= 1'b0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				chol_pkg::ST_IDLE: if (go) begin
					j_q <= '0; bad_q <= 1'b0;
					n_q <= IW'(pc * 6);
				end
				chol_pkg::ST_DIAG_INIT: k_q <= '0;
				chol_pkg::ST_DIAG_RD: ;
				chol_pkg::ST_DIAG_ACC: if (k_q != j_q) k_q <= k_q + 1'b1;
				chol_pkg::ST_SQRT: ;
				chol_pkg::ST_PIV_WR: begin
					if (stat.piv_zero) bad_q <= 1'b1;
					i_q <= j_q + 1'b1;
					if (j_q + 1'b1 == n_q) i_q <= '0;
				end
				chol_pkg::ST_OFF_INIT: k_q <= '0;
				chol_pkg::ST_OFF_RD: ;
				chol_pkg::ST_OFF_ACC: if (k_q != j_q) k_q <= k_q + 1'b1;
				chol_pkg::ST_DIV: ;
				chol_pkg::ST_OFF_WR: begin
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == n_q) j_q <= j_q + 1'b1;
				end
				chol_pkg::ST_OUT_INIT: k_q <= '0;
				chol_pkg::ST_OUT_RD: k_q <= k_q + 1'b1;
				chol_pkg::ST_OUT_ACC: if (k_q != i_q + 1'b1) k_q <= k_q + 1'b1;
				chol_pkg::ST_OUT_MUL: ;
				chol_pkg::ST_OUT_EMIT: i_q <= i_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign busy = st_q != chol_pkg::ST_IDLE;
	assign bad = bad_q;
endmodule
`default_nettype wire

>>> rtl/core/cholesky_correlated_noise.sv
`default_nettype none
// channel   signals                      transfer
// cmd       start, busy, cmd            start && !busy
// result    res_valid, res               res_valid, one cycle, no stall
// config    cfg_we, cfg_idx, cfg_data    cfg_we
// a load is written as it is taken; the last item starts factoring, roughly
// n^3/6 multiply steps plus a square root per pivot and a divide per
// element below a nonzero pivot, then n output rows;
// busy is high throughout
// reset clears control and the config registers; stores are undefined until written
// the receiver cannot stall results
module cholesky_correlated_noise (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire chol_pkg::in_item_t cmd,
	output logic res_valid,
	output chol_pkg::out_item_t res,
	input wire logic cfg_we,
	input wire logic cfg_idx,
	input wire logic [chol_pkg::CFG_W-1:0] cfg_data
);
	logic [3:0] pc_q;
	logic [30:0] ns_q;
	logic acc, load_we, go, bad;
	chol_pkg::ctrl_t ctrl;
	chol_pkg::stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 4'd8;
			ns_q <= 31'd16777216;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				chol_pkg::CFG_IDX_PC: pc_q <= cfg_data[3:0];
				chol_pkg::CFG_IDX_NS: ns_q <= cfg_data;
			endcase
		end
	end

	assign acc = start && !busy;
	// out-of-range positions and upper-triangle elements are dropped
	assign load_we = acc && cmd.row < 6'(chol_pkg::MAX_DIM) &&
		(cmd.mode == chol_pkg::MODE_SAMPLE || cmd.col <= cmd.row);
	assign go = acc && cmd.last;

	chol_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .go(go), .particle_count(pc_q),
		.stat(stat), .busy(busy), .bad(bad), .ctrl(ctrl));
	chol_datapath u_dp (.clk(clk), .arst_n(arst_n), .load_we(load_we), .load_item(cmd),
		.ctrl(ctrl), .noise_scale(ns_q), .bad(bad), .stat(stat),
		.res_strobe(res_valid), .res(res));
endmodule
`default_nettype wire

>>> rtl/core/chol_checker.sv
`default_nettype none
module chol_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire chol_pkg::in_item_t cmd,
	input wire logic res_valid,
	input wire chol_pkg::out_item_t res
);
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.final_res |=> !busy) else $error("busy after final");
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy) else $error("result while idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !cmd.last |=> !busy) else $error("busy after plain load");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid) else $error("back to back results");
endmodule
bind cholesky_correlated_noise chol_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .cmd(cmd), .res_valid(res_valid), .res(res));
`default_nettype wire

>>> bench/cholesky_correlated_noise_tb.sv
module cholesky_correlated_noise_tb;
	import chol_pkg::*;

	// worst case: a 48-wide factoring runs long with no transfer,
	// and the limit is set well above it
	localparam int STALL_LIMIT = 500000;

	typedef enum int {FILL_WELL, FILL_RANDOM, FILL_UNIT, FILL_BAD_PIVOT} fill_t;
	typedef enum int {TAIL_SAMPLE, TAIL_ELEM, TAIL_IGNORED} tail_t;

	// model of the block: stores, registers and the expected displacements
	class noise_scoreboard;
		int mat[MAX_DIM*MAX_DIM];
		int samp[MAX_DIM];
		int unsigned pcount = 8;
		int unsigned nscale = 16777216;
		out_item_t due[$];
		int errors, results, runs, bad_runs;

		function void set_reg(logic idx, logic [CFG_W-1:0] d);
			if (idx == CFG_IDX_PC) pcount = d[3:0];
			else nscale = d;
		endfunction

		function longint clamp64(logic signed [64:0] s);
			if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
			if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
			return s[63:0];
		endfunction

		function longint add64(longint a, longint b);
			logic signed [64:0] s;
			s = a;
			s = s + b;
			return clamp64(s);
		endfunction

		function longint sub64(longint a, longint b);
			logic signed [64:0] s;
			s = a;
			s = s - b;
			return clamp64(s);
		endfunction

		function int clamp32(longint x);
			if (x > 64'sd2147483647) return 32'sh7fffffff;
			if (x < -64'sd2147483648) return 32'sh80000000;
			return x[31:0];
		endfunction

		// round half up from Q.2F to Q.F
		function longint round_frac(longint x);
			longint t;
			t = add64(x, 64'sd1 <<< (FRAC_BITS - 1));
			return t >>> FRAC_BITS;
		endfunction

		function longint unsigned floor_root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// in-place column-wise cholesky factoring; returns 1 when some pivot was not positive
		function bit factor_in_place(int n);
			bit bad;
			longint acc, piv, num;
			longint unsigned r;
			bad = 0;
			for (int j = 0; j < n; j++) begin
				acc = longint'(mat[j*MAX_DIM+j]) <<< FRAC_BITS;
				for (int k = 0; k < j; k++)
					acc = sub64(acc, longint'(mat[j*MAX_DIM+k]) * longint'(mat[j*MAX_DIM+k]));
				piv = 0;
				if (acc > 0) begin
					r = floor_root(acc);
					piv = (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
				end
				mat[j*MAX_DIM+j] = piv;
				if (piv == 0) begin
					bad = 1;
					for (int i = j + 1; i < n; i++) mat[i*MAX_DIM+j] = 0;
				end else begin
					for (int i = j + 1; i < n; i++) begin
						num = longint'(mat[i*MAX_DIM+j]) <<< FRAC_BITS;
						for (int k = 0; k < j; k++)
							num = sub64(num,
								longint'(mat[i*MAX_DIM+k]) * longint'(mat[j*MAX_DIM+k]));
						mat[i*MAX_DIM+j] = clamp32(num / piv);
					end
				end
			end
			return bad;
		endfunction

		function void note_input(in_item_t it);
			int unsigned p;
			int n;
			bit bad;
			longint acc;
			int v;
			out_item_t o;
			if (it.mode == MODE_SAMPLE) begin
				if (it.row < MAX_DIM) samp[it.row] = it.value;
			end else if (it.row < MAX_DIM && it.col <= it.row) begin
				mat[it.row*MAX_DIM+it.col] = it.value;
			end
			if (!it.last) return;
			p = pcount;
			if (p < 1) p = 1;
			if (p > MAX_PC) p = MAX_PC;
			n = 6 * p;
			bad = factor_in_place(n);
			runs++;
			if (bad) bad_runs++;
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j <= i; j++)
					acc = add64(acc, longint'(mat[i*MAX_DIM+j]) * longint'(samp[j]));
				v = clamp32(round_frac(acc));
				o.index = i;
				o.displacement = clamp32(round_frac(longint'(v) * longint'(nscale)));
				o.not_pos_def = bad;
				o.final_res = (i == n - 1);
				due.push_back(o);
			end
		endfunction

		function void check_result(out_item_t r);
			out_item_t e;
			results++;
			if (due.size() == 0) begin
				$error("unexpected displacement index %0d value %0d", r.index, r.displacement);
				errors++;
				return;
			end
			e = due.pop_front();
			if (r.index !== e.index) begin
				$error("index: expected %0d got %0d", e.index, r.index);
				errors++;
			end
			if (r.displacement !== e.displacement) begin
				$error("displacement: expected %0d got %0d", e.displacement, r.displacement);
				errors++;
			end
			if (r.not_pos_def !== e.not_pos_def) begin
				$error("not_pos_def: expected %0b got %0b", e.not_pos_def, r.not_pos_def);
				errors++;
			end
			if (r.final_res !== e.final_res) begin
				$error("final_res: expected %0b got %0b", e.final_res, r.final_res);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t cmd = '0;
	logic res_valid;
	out_item_t res;
	logic cfg_we = 1'b0;
	logic cfg_idx = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	noise_scoreboard sb = new();
	int idle_pct;		// chance in percent of a gap after each command transfer
	int items_sent;
	int quiet_cycles;
	int max_dim_seen;

	cholesky_correlated_noise uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.res_valid(res_valid),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// monitor: every transfer is seen here on the edge that makes it;
	// the watchdog counts edges with no transfer at all
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_input(cmd);
			if (res_valid) sb.check_result(res);
			if ((start && !busy) || res_valid || cfg_we) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// present one command and hold it until the block takes it;
	// start stays high into the next command unless a gap is drawn
	task automatic send_cmd(in_item_t it);
		start <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (busy);
		items_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
		cfg_we <= 1'b0;
	endtask

	// pause the sender until every displacement is out and the block is free
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.due.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic in_item_t ignored_cmd();
		in_item_t it;
		it.mode = $urandom_range(1);
		it.value = $urandom;
		it.last = 1'b0;
		if (it.mode == MODE_SAMPLE || $urandom_range(1)) begin
			it.row = $urandom_range(MAX_DIM, 63);
			it.col = $urandom_range(63);
		end else begin
			it.row = $urandom_range(MAX_DIM - 2);
			it.col = $urandom_range(it.row + 1, 63);
		end
		return it;
	endfunction

	function automatic logic signed [31:0] pick_extreme();
		case ($urandom_range(4))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			3: return -32'sd1;
			default: return 32'sh01000000;
		endcase
	endfunction

	// load a full lower triangle and sample vector of the given dimension in
	// shuffled order, sprinkle in ignored commands, then mark the last one
	task automatic run_load(int n, fill_t fill, tail_t tail, int n_ignored);
		in_item_t q[$];
		in_item_t it, tmp;
		int bad_j, k;
		bad_j = $urandom_range(n - 1);
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c <= r; c++) begin
				it.mode = MODE_ELEM;
				it.row = r;
				it.col = c;
				it.last = 1'b0;
				case (fill)
					FILL_RANDOM: it.value = $urandom;
					FILL_UNIT: it.value = (r == c) ? 32'sh01000000 : 32'sh0;
					default: begin
						if (r == c) it.value = (n << FRAC_BITS) + $urandom_range(1 << FRAC_BITS);
						else it.value = $signed($urandom_range(1 << FRAC_BITS)) - (1 << 23);
						if (fill == FILL_BAD_PIVOT && r == bad_j && c == r)
							it.value = $urandom_range(1) ? 32'sh0 : -$signed($urandom_range(1, 1 << 30));
					end
				endcase
				q.push_back(it);
			end
			it.mode = MODE_SAMPLE;
			it.row = r;
			it.col = $urandom_range(63);
			case (fill)
				FILL_RANDOM: it.value = $urandom;
				FILL_UNIT: it.value = pick_extreme();
				default: it.value = $signed($urandom_range(1 << 27)) - (1 << 26);
			endcase
			q.push_back(it);
		end
		for (int i = 0; i < n_ignored; i++) q.push_back(ignored_cmd());
		for (int i = q.size() - 1; i > 0; i--) begin
			k = $urandom_range(i);
			tmp = q[i];
			q[i] = q[k];
			q[k] = tmp;
		end
		if (tail == TAIL_IGNORED) begin
			it = ignored_cmd();
			q.push_back(it);
		end else begin
			// bring a real load of the wanted kind to the end
			for (int i = q.size() - 1; i >= 0; i--) begin
				if (q[i].row < MAX_DIM && q[i].col <= q[i].row &&
						q[i].mode == (tail == TAIL_SAMPLE ? MODE_SAMPLE : MODE_ELEM) ||
						tail == TAIL_SAMPLE && q[i].mode == MODE_SAMPLE && q[i].row < MAX_DIM) begin
					tmp = q[i];
					q[i] = q[q.size()-1];
					q[q.size()-1] = tmp;
					break;
				end
			end
		end
		q[q.size()-1].last = 1'b1;
		if (n > max_dim_seen) max_dim_seen = n;
		foreach (q[i]) send_cmd(q[i]);
	endtask

	function automatic int dim_of(int unsigned p);
		if (p < 1) p = 1;
		if (p > MAX_PC) p = MAX_PC;
		return 6 * p;
	endfunction

	task automatic random_run();
		int unsigned p;
		int w;
		fill_t fill;
		drain();
		case ($urandom_range(1))
			0: p = 0;
			default: p = 1;
		endcase
		// upper data bits of the count register must not matter
		write_reg(CFG_IDX_PC, {$urandom_range(0, (1 << 27) - 1), p[3:0]});
		if ($urandom_range(2) == 0) write_reg(CFG_IDX_NS, $urandom);
		else write_reg(CFG_IDX_NS, $urandom_range(1 << 25));
		w = $urandom_range(99);
		fill = (w < 60) ? FILL_WELL : (w < 75) ? FILL_BAD_PIVOT : (w < 90) ? FILL_RANDOM : FILL_UNIT;
		run_load(dim_of(p), fill, tail_t'($urandom_range(2)), $urandom_range(3));
	endtask

	initial begin
		quiet_cycles = 0;
		idle_pct = 17;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: count zero acts as one particle on a unit matrix with extreme
		// samples, then a non-positive pivot, then scale extremes, the largest saturating
		write_reg(CFG_IDX_PC, '0);
		write_reg(CFG_IDX_NS, 31'h0100_0000);
		run_load(6, FILL_UNIT, TAIL_SAMPLE, 2);
		drain();
		write_reg(CFG_IDX_NS, {CFG_W{1'b1}});
		run_load(6, FILL_BAD_PIVOT, TAIL_ELEM, 1);
		drain();
		write_reg(CFG_IDX_NS, '0);
		run_load(6, FILL_RANDOM, TAIL_IGNORED, 1);
		drain();
		write_reg(CFG_IDX_PC, 31'd1);
		write_reg(CFG_IDX_NS, {CFG_W{1'b1}});
		run_load(6, FILL_UNIT, TAIL_ELEM, 0);

		// random: sender gaps often, then never
		idle_pct = 50;
		random_run();
		idle_pct = 0;
		random_run();

		drain();
		repeat (50) @(posedge clk);
		if (sb.due.size() != 0) begin
			$error("%0d displacements never arrived", sb.due.size());
			sb.errors++;
		end
		$display("covered %0d commands in %0d runs (%0d with a bad pivot), largest dim %0d",
			items_sent, sb.runs, sb.bad_runs, max_dim_seen);
		$display("checked %0d displacements, %0d mismatches", sb.results, sb.errors);
		if (sb.errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
